>>> design/ttdt_pkg.sv
`default_nettype none

package ttdt_pkg;

  // Default number of task slots.
  localparam int unsigned NumSlotsDef = 8;

  // Field widths of one request transfer.
  localparam int unsigned ReqW    = 2;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned InDataW = 40;

  // Request codes carried on tuser.
  typedef enum logic [ReqW-1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

endpackage

`default_nettype wire

>>> design/tick_task_delay_table.sv
`default_nettype none

// Tick engine of a time-triggered cooperative scheduler. The block holds
// NUM_SLOTS task slots (present flag, remaining delay, reload period, due
// flag). A tick request walks the slots one per cycle through a single
// shared decrement and compare unit, fed from the delay and period memories:
// a present slot with zero delay becomes due and reloads its period (when
// nonzero), any other present slot counts down by one. A tick's result is
// loaded into the output register after the walk has updated the last slot,
// and the input is ready again once that load is done; the load waits while
// an older result is still pending. A write or clear request goes straight
// to that output load. Every request returns the due mask of the first eight
// slots on the output stream. The input side is not ready while a request is
// in work, but it takes the next request while the previous result waits in
// the output register.
module tick_task_delay_table #(
  parameter int unsigned NUM_SLOTS = ttdt_pkg::NumSlotsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Request stream.
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata from bit 0 up: task_index[2:0], start_delay[15:0],
  // repeat_period[15:0], task_present, zero fill.
  input  wire logic [ttdt_pkg::InDataW-1:0] s_axis_tdata_i,
  // tuser: req_type[1:0].
  input  wire logic [ttdt_pkg::ReqW-1:0]    s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // tdata from bit 0 up: due_mask[7:0].
  output logic [ttdt_pkg::MaskW-1:0]        m_axis_tdata_o
);
  import ttdt_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_OUT
  } state_e;

  // Unpacked request fields.
  logic [IndexW-1:0] in_index;
  logic [DelayW-1:0] in_delay;
  logic [DelayW-1:0] in_period;
  logic              in_present;
  req_e              in_req;

  assign in_index   = s_axis_tdata_i[2:0];
  assign in_delay   = s_axis_tdata_i[18:3];
  assign in_period  = s_axis_tdata_i[34:19];
  assign in_present = s_axis_tdata_i[35];
  assign in_req     = req_e'(s_axis_tuser_i);

  state_e                 state_q, state_d;
  logic [NUM_SLOTS-1:0]   present_q, present_d;
  logic [NUM_SLOTS-1:0]   due_q, due_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   rd_busy_q, rd_busy_d;
  logic [IdxW-1:0]        upd_idx_q, upd_idx_d;
  logic                   upd_v_q, upd_v_d;
  logic                   out_valid_q, out_valid_d;
  logic [MaskW-1:0]       out_data_q, out_data_d;

  // Slot memories with registered read data.
  logic [DelayW-1:0] delay_mem [NUM_SLOTS];
  logic [DelayW-1:0] period_mem [NUM_SLOTS];
  logic [DelayW-1:0] dly_rd_q;
  logic [DelayW-1:0] per_rd_q;

  logic              in_xfer;
  logic              idx_ok;
  logic [IdxW-1:0]   in_slot;
  logic              dly_we;
  logic [IdxW-1:0]   dly_waddr;
  logic [DelayW-1:0] dly_wdata;
  logic              per_we;
  logic [NUM_SLOTS+MaskW-1:0] due_ext;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_ok          = (32'(in_index) < NUM_SLOTS);
  assign in_slot         = IdxW'(in_index);
  assign per_we          = in_xfer && (in_req == REQ_WRITE) && idx_ok;
  assign due_ext         = {{MaskW{1'b0}}, due_d};

  // Sequencer and the shared update unit.
  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    due_d       = due_q;
    rd_idx_d    = rd_idx_q;
    rd_busy_d   = rd_busy_q;
    upd_idx_d   = upd_idx_q;
    upd_v_d     = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    dly_we      = 1'b0;
    dly_waddr   = in_slot;
    dly_wdata   = in_delay;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_OUT;
          case (in_req)
            REQ_TICK: begin
              state_d   = S_TICK;
              rd_idx_d  = '0;
              rd_busy_d = 1'b1;
            end
            REQ_WRITE: begin
              if (idx_ok) begin
                present_d[in_slot] = in_present;
                due_d[in_slot]     = 1'b0;
                dly_we             = 1'b1;
              end
            end
            REQ_CLEAR: begin
              if (idx_ok) begin
                due_d[in_slot] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        // Read issue for the next slot.
        if (rd_busy_q) begin
          upd_v_d   = 1'b1;
          upd_idx_d = rd_idx_q;
          if (rd_idx_q == LastIdx) begin
            rd_busy_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // Update of the slot whose data arrived this cycle.
        if (upd_v_q) begin
          dly_waddr = upd_idx_q;
          if (present_q[upd_idx_q]) begin
            if (dly_rd_q == '0) begin
              due_d[upd_idx_q] = 1'b1;
              dly_wdata        = per_rd_q;
              dly_we           = (per_rd_q != '0);
            end else begin
              dly_wdata = dly_rd_q - 1'b1;
              dly_we    = 1'b1;
            end
          end
          if (upd_idx_q == LastIdx) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = due_ext[MaskW-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      due_q       <= '0;
      rd_idx_q    <= '0;
      rd_busy_q   <= 1'b0;
      upd_idx_q   <= '0;
      upd_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      due_q       <= due_d;
      rd_idx_q    <= rd_idx_d;
      rd_busy_q   <= rd_busy_d;
      upd_idx_q   <= upd_idx_d;
      upd_v_q     <= upd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // Delay and period memories. A slot's contents are only used once a write
  // has made it present, so the memories need no reset.
  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      delay_mem[dly_waddr] <= dly_wdata;
    end
    if (per_we) begin
      period_mem[in_slot] <= in_period;
    end
    dly_rd_q <= delay_mem[rd_idx_q];
    per_rd_q <= period_mem[rd_idx_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // A tick transfer starts the slot walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_req == REQ_TICK)) |=> (state_q == S_TICK) && rd_busy_q)
    else $error("tick did not start the slot walk");

  // The walk only updates slots that exist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_v_q |-> (32'(upd_idx_q) < NUM_SLOTS))
    else $error("slot update beyond the table");

  // Due flags only fall on a write or clear transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(due_q) & ~due_q) != '0) |->
      $past(in_xfer && ((in_req == REQ_WRITE) || (in_req == REQ_CLEAR))))
    else $error("due flag dropped without a write or clear");

  // A clear of an existing slot leaves its due flag low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_req == REQ_CLEAR) && idx_ok) |=> !due_q[$past(in_slot)])
    else $error("clear did not drop the due flag");

  // No new result is loaded while an old one is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(out_data_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
